@@ hdl/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex normal averager package
// Shared types, codes and fixed widths of the vertex normal averager: the
// opcodes, the result status codes, and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

   // Field widths fixed by the interface.
   localparam int IDX_W  = 10;
   localparam int POS_W  = 16;
   localparam int NORM_W = 16;
   localparam int CNT_W  = 11;
   localparam int ACC_W  = 24;

   // Internal datapath widths.
   localparam int EDGE_W   = POS_W + 1;     // difference of two positions
   localparam int VEC_W    = 36;            // cross product or accumulator value
   localparam int MAG_W    = 35;            // magnitude before range reduction
   localparam int RED_W    = 30;            // magnitude after range reduction
   localparam int MUL_W    = RED_W + 1;     // signed multiplier operand
   localparam int PROD_W   = 2 * MUL_W;     // signed multiplier product
   localparam int SUM_W    = 64;            // sum of squares and root registers
   localparam int LEN_W    = 31;            // vector length
   localparam int FRAC_W   = 14;            // fraction bits of Q1.14
   localparam int QUO_W    = FRAC_W + 1;    // quotient, at most one in Q1.14
   localparam int REM_W    = RED_W + FRAC_W + 2;
   localparam int STEP_W   = 5;             // sequencer step counter

   // Sequencer step counts.
   localparam int CROSS_STEPS = 6;
   localparam int SQ_STEPS    = 3;
   localparam int ROOT_STEPS  = 32;
   localparam int DIV_STEPS   = QUO_W;
   localparam int CORNERS     = 3;

   // Accumulator saturation bounds.
   localparam logic signed [ACC_W:0] ACC_HI = 25'sd8388607;
   localparam logic signed [ACC_W:0] ACC_LO = -25'sd8388608;

   localparam logic [CNT_W-1:0] VCOUNT_RESET = 11'd1024;

   // Operations.
   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   // Triangle corner selection.
   localparam logic [1:0] CORNER_A = 2'd0;
   localparam logic [1:0] CORNER_B = 2'd1;
   localparam logic [1:0] CORNER_C = 2'd2;

   // Multiplier operand selection: six cross product terms, then three squares.
   localparam logic [3:0] MS_CX_P = 4'd0;
   localparam logic [3:0] MS_CX_N = 4'd1;
   localparam logic [3:0] MS_CY_P = 4'd2;
   localparam logic [3:0] MS_CY_N = 4'd3;
   localparam logic [3:0] MS_CZ_P = 4'd4;
   localparam logic [3:0] MS_CZ_N = 4'd5;
   localparam logic [3:0] MS_SQ_X = 4'd6;
   localparam logic [3:0] MS_SQ_Y = 4'd7;
   localparam logic [3:0] MS_SQ_Z = 4'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       req_take;
      logic       pos_wr;
      logic       pos_cap;
      logic [1:0] corner_sel;
      logic       edge_load;
      logic       mul_valid;
      logic [3:0] mul_sel;
      logic       acc_cap;
      logic       abs_load;
      logic       mag_shift;
      logic       sum_clear;
      logic       root_init;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       acc_wr_upd;
      logic       clr_start;
      logic       clr_step;
      logic       out_load;
      logic       out_use_norm;
      logic [1:0] out_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       a_bad;
      logic       any_bad;
      logic       shift_more;
      logic       len_zero;
      logic       clr_last;
   } stat_type;

endpackage

@@ hdl/vna_ram.sv @@
// ----------------------------------------------------------------------------
// Vertex normal averager RAM
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/vna_datapath.sv @@
// ----------------------------------------------------------------------------
// Vertex normal averager datapath
// Request and configuration registers, position and accumulator memories,
// the shared multiplier, the bit-serial square root, three shift-subtract
// dividers, saturating update and the result register.
// ----------------------------------------------------------------------------
module vna_datapath import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CNT_W-1:0]         csr_wdata,
   input  logic [1:0]               req_opcode,
   input  logic [IDX_W-1:0]         req_index_a,
   input  logic [IDX_W-1:0]         req_index_b,
   input  logic [IDX_W-1:0]         req_index_c,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic [1:0]               rsp_status
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int LW = $clog2(MAX_VERTICES + 1);
   localparam int CW = (LW > CNT_W) ? LW : CNT_W;

   // Saturating add of a face normal component to an accumulator component.
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic signed [NORM_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = $signed({a[ACC_W-1], a}) + (ACC_W + 1)'(b);
      if (s > ACC_HI) begin
         return ACC_HI[ACC_W-1:0];
      end else if (s < ACC_LO) begin
         return ACC_LO[ACC_W-1:0];
      end
      return s[ACC_W-1:0];
   endfunction

   logic [CNT_W-1:0]         vertex_count_ff;
   logic [1:0]               op_ff;
   logic [IDX_W-1:0]         ia_ff, ib_ff, ic_ff;
   logic [3*POS_W-1:0]       pos_in_ff;
   logic [CW-1:0]            lim;
   logic [IDX_W-1:0]         corner_idx;
   logic [AW-1:0]            addr;
   logic [3*POS_W-1:0]       pos_q;
   logic [3*ACC_W-1:0]       acc_q;
   logic [3*ACC_W-1:0]       acc_upd;
   logic [3*ACC_W-1:0]       acc_wdata;
   logic [AW-1:0]            acc_waddr;
   logic                     acc_we;
   logic [AW-1:0]            sweep_ff;
   logic [3*POS_W-1:0]       pa_ff, pb_ff, pc_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [3:0]               tag_ff;
   logic                     tag_valid_ff;
   logic signed [VEC_W-1:0]  vec_ff [3];
   logic [MAG_W-1:0]         mag_ff [3];
   logic                     neg_ff [3];
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         root_x_ff, root_res_ff, root_bit_ff;
   logic [SUM_W-1:0]         root_trial;
   logic [LEN_W-1:0]         len;
   logic [REM_W-1:0]         rem_ff [3];
   logic [REM_W-1:0]         dsh_ff;
   logic [QUO_W-1:0]         quo_ff [3];
   logic signed [NORM_W-1:0] nrm [3];
   logic signed [NORM_W-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic [1:0]               status_ff;

   // Configuration register and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCOUNT_RESET;
      end else if (csr_we) begin
         vertex_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         op_ff     <= req_opcode;
         ia_ff     <= req_index_a;
         ib_ff     <= req_index_b;
         ic_ff     <= req_index_c;
         pos_in_ff <= {req_pos_z, req_pos_y, req_pos_x};
      end
   end

   // Index range checks against the effective vertex count.
   assign lim = (CW'(vertex_count_ff) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                           : CW'(vertex_count_ff);
   assign stat.opcode  = op_ff;
   assign stat.a_bad   = CW'(ia_ff) >= lim;
   assign stat.any_bad = (CW'(ia_ff) >= lim) || (CW'(ib_ff) >= lim) || (CW'(ic_ff) >= lim);

   // Corner address selection.
   always_comb begin
      unique case (cmd.corner_sel)
         CORNER_B: corner_idx = ib_ff;
         CORNER_C: corner_idx = ic_ff;
         default:  corner_idx = ia_ff;
      endcase
   end
   assign addr = AW'(corner_idx);

   // Position memory.
   vna_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.pos_wr),
      .wr_addr (AW'(ia_ff)),
      .wr_data (pos_in_ff),
      .rd_addr (addr),
      .rd_data (pos_q)
   );

   // Accumulator memory, written by the clearing sweep or by a corner update.
   assign acc_we    = cmd.clr_step || cmd.acc_wr_upd;
   assign acc_waddr = cmd.clr_step ? sweep_ff : addr;
   assign acc_wdata = cmd.clr_step ? '0 : acc_upd;

   vna_ram #(.WIDTH(3 * ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (addr),
      .rd_data (acc_q)
   );

   // Clearing sweep address.
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         sweep_ff <= '0;
      end else if (cmd.clr_step) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end
   assign stat.clr_last = sweep_ff == AW'(MAX_VERTICES - 1);

   // Corner positions and edge vectors.
   always_ff @(posedge clock) begin
      if (cmd.pos_cap) begin
         unique case (cmd.corner_sel)
            CORNER_B: pb_ff <= pos_q;
            CORNER_C: pc_ff <= pos_q;
            default:  pa_ff <= pos_q;
         endcase
      end
      if (cmd.edge_load) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= EDGE_W'($signed(pb_ff[i*POS_W +: POS_W]))
                      - EDGE_W'($signed(pa_ff[i*POS_W +: POS_W]));
            e2_ff[i] <= EDGE_W'($signed(pc_ff[i*POS_W +: POS_W]))
                      - EDGE_W'($signed(pa_ff[i*POS_W +: POS_W]));
         end
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MS_CX_P: begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[2]); end
         MS_CX_N: begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[1]); end
         MS_CY_P: begin mul_a = MUL_W'(e1_ff[2]); mul_b = MUL_W'(e2_ff[0]); end
         MS_CY_N: begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[2]); end
         MS_CZ_P: begin mul_a = MUL_W'(e1_ff[0]); mul_b = MUL_W'(e2_ff[1]); end
         MS_CZ_N: begin mul_a = MUL_W'(e1_ff[1]); mul_b = MUL_W'(e2_ff[0]); end
         MS_SQ_X: begin
            mul_a = $signed({1'b0, mag_ff[0][RED_W-1:0]});
            mul_b = mul_a;
         end
         MS_SQ_Y: begin
            mul_a = $signed({1'b0, mag_ff[1][RED_W-1:0]});
            mul_b = mul_a;
         end
         MS_SQ_Z: begin
            mul_a = $signed({1'b0, mag_ff[2][RED_W-1:0]});
            mul_b = mul_a;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // Product register with its operand tag.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      tag_ff  <= cmd.mul_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= cmd.mul_valid;
      end
   end

   // Vector under normalization: cross product accumulation or accumulator load.
   always_ff @(posedge clock) begin
      if (cmd.edge_load) begin
         for (int i = 0; i < 3; i++) begin
            vec_ff[i] <= '0;
         end
      end else if (cmd.acc_cap) begin
         for (int i = 0; i < 3; i++) begin
            vec_ff[i] <= VEC_W'($signed(acc_q[i*ACC_W +: ACC_W]));
         end
      end else if (tag_valid_ff && (tag_ff < MS_SQ_X)) begin
         for (int i = 0; i < 3; i++) begin
            if (tag_ff[2:1] == 2'(i)) begin
               vec_ff[i] <= tag_ff[0] ? vec_ff[i] - $signed(prod_ff[VEC_W-1:0])
                                      : vec_ff[i] + $signed(prod_ff[VEC_W-1:0]);
            end
         end
      end
   end

   // Sum of squares.
   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (tag_valid_ff && (tag_ff >= MS_SQ_X)) begin
         sum_ff <= sum_ff + {{(SUM_W - PROD_W){1'b0}}, prod_ff};
      end
   end

   // Magnitudes and signs, with range reduction one bit a cycle.
   always_ff @(posedge clock) begin
      if (cmd.abs_load) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= vec_ff[i] < 0;
            mag_ff[i] <= (vec_ff[i] < 0) ? MAG_W'(-vec_ff[i]) : MAG_W'(vec_ff[i]);
         end
      end else if (cmd.mag_shift) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_ff[i] >> 1;
         end
      end
   end
   assign stat.shift_more = (|mag_ff[0][MAG_W-1:RED_W]) || (|mag_ff[1][MAG_W-1:RED_W])
                         || (|mag_ff[2][MAG_W-1:RED_W]);

   // Bit-serial integer square root, one result bit a cycle.
   assign root_trial = root_res_ff + root_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         root_x_ff   <= sum_ff;
         root_res_ff <= '0;
         root_bit_ff <= SUM_W'(1) << (SUM_W - 2);
      end else if (cmd.root_step) begin
         if (root_x_ff >= root_trial) begin
            root_x_ff   <= root_x_ff - root_trial;
            root_res_ff <= (root_res_ff >> 1) + root_bit_ff;
         end else begin
            root_res_ff <= root_res_ff >> 1;
         end
         root_bit_ff <= root_bit_ff >> 2;
      end
   end
   assign len           = root_res_ff[LEN_W-1:0];
   assign stat.len_zero = root_res_ff == '0;

   // Three restoring dividers sharing one shifted divisor.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dsh_ff <= REM_W'({len, {FRAC_W{1'b0}}});
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= REM_W'({mag_ff[i][RED_W-1:0], {FRAC_W{1'b0}}})
                       + REM_W'(len >> 1);
            quo_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[i] >= dsh_ff) begin
               rem_ff[i] <= rem_ff[i] - dsh_ff;
               quo_ff[i] <= {quo_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               quo_ff[i] <= {quo_ff[i][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // Signed unit normal and saturating corner update.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i] = neg_ff[i] ? -$signed({1'b0, quo_ff[i]}) : $signed({1'b0, quo_ff[i]});
         acc_upd[i*ACC_W +: ACC_W] = sat_add(acc_q[i*ACC_W +: ACC_W], nrm[i]);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         norm_x_ff <= cmd.out_use_norm ? nrm[0] : '0;
         norm_y_ff <= cmd.out_use_norm ? nrm[1] : '0;
         norm_z_ff <= cmd.out_use_norm ? nrm[2] : '0;
         status_ff <= cmd.out_status;
      end
   end

   assign rsp_norm_x = norm_x_ff;
   assign rsp_norm_y = norm_y_ff;
   assign rsp_norm_z = norm_z_ff;
   assign rsp_status = status_ff;

endmodule

@@ hdl/vna_ctrl.sv @@
// ----------------------------------------------------------------------------
// Vertex normal averager controller
// State machine that sequences each operation through the datapath and
// handles both handshakes.
// ----------------------------------------------------------------------------
module vna_ctrl import vna_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [21:0] {
      S_INIT   = 22'h000001,
      S_IDLE   = 22'h000002,
      S_DECODE = 22'h000004,
      S_CLEAR  = 22'h000008,
      S_PREAD  = 22'h000010,
      S_PCAP   = 22'h000020,
      S_EDGE   = 22'h000040,
      S_CROSS  = 22'h000080,
      S_CDRAIN = 22'h000100,
      S_AREAD  = 22'h000200,
      S_ACAP   = 22'h000400,
      S_ABS    = 22'h000800,
      S_SHIFT  = 22'h001000,
      S_SQUARE = 22'h002000,
      S_SDRAIN = 22'h004000,
      S_ROOT0  = 22'h008000,
      S_ROOT   = 22'h010000,
      S_LENCHK = 22'h020000,
      S_DIV    = 22'h040000,
      S_UREAD  = 22'h080000,
      S_UWRITE = 22'h100000,
      S_FINISH = 22'h200000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [1:0]        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      st_in     = st_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            st_in  = ST_OK;
            cnt_in = '0;
            unique case (stat.opcode)
               OP_LOAD: begin
                  if (stat.a_bad) begin
                     st_in = ST_RANGE;
                  end else begin
                     cmd.pos_wr = 1'b1;
                  end
                  state_in = S_FINISH;
               end
               OP_TRIANGLE: begin
                  if (stat.any_bad) begin
                     st_in    = ST_RANGE;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_PREAD;
                  end
               end
               OP_READ: begin
                  if (stat.a_bad) begin
                     st_in    = ST_RANGE;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_AREAD;
                  end
               end
               default: begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLEAR;
               end
            endcase
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_FINISH;
            end
         end
         S_PREAD: begin
            cmd.corner_sel = cnt_ff[1:0];
            state_in       = S_PCAP;
         end
         S_PCAP: begin
            cmd.corner_sel = cnt_ff[1:0];
            cmd.pos_cap    = 1'b1;
            if (cnt_ff == STEP_W'(CORNERS - 1)) begin
               state_in = S_EDGE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_PREAD;
            end
         end
         S_EDGE: begin
            cmd.edge_load = 1'b1;
            cnt_in        = '0;
            state_in      = S_CROSS;
         end
         S_CROSS: begin
            cmd.mul_valid = 1'b1;
            cmd.mul_sel   = MS_CX_P + 4'(cnt_ff);
            if (cnt_ff == STEP_W'(CROSS_STEPS - 1)) begin
               state_in = S_CDRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CDRAIN: begin
            state_in = S_ABS;
         end
         S_AREAD: begin
            cmd.corner_sel = CORNER_A;
            state_in       = S_ACAP;
         end
         S_ACAP: begin
            cmd.corner_sel = CORNER_A;
            cmd.acc_cap    = 1'b1;
            state_in       = S_ABS;
         end
         S_ABS: begin
            cmd.abs_load  = 1'b1;
            cmd.sum_clear = 1'b1;
            state_in      = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.shift_more) begin
               cmd.mag_shift = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.mul_valid = 1'b1;
            cmd.mul_sel   = MS_SQ_X + 4'(cnt_ff);
            if (cnt_ff == STEP_W'(SQ_STEPS - 1)) begin
               state_in = S_SDRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SDRAIN: begin
            state_in = S_ROOT0;
         end
         S_ROOT0: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = S_LENCHK;
            end
         end
         S_LENCHK: begin
            if (stat.len_zero) begin
               st_in    = ST_ZERO;
               state_in = S_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = (stat.opcode == OP_READ) ? S_FINISH : S_UREAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_UREAD: begin
            cmd.corner_sel = cnt_ff[1:0];
            state_in       = S_UWRITE;
         end
         S_UWRITE: begin
            cmd.corner_sel = cnt_ff[1:0];
            cmd.acc_wr_upd = 1'b1;
            if (cnt_ff == STEP_W'(CORNERS - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_UREAD;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load     = 1'b1;
               cmd.out_status   = st_ff;
               cmd.out_use_norm = (stat.opcode == OP_READ) && (st_ff == ST_OK);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid flag: set on a load, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         st_ff        <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // An accepted beat is decoded in the following cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted beat not decoded");

   // The state register always holds exactly one active bit.
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   // The cross product sequence never runs past its last term.
   a_cross_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CROSS) |-> (cnt_ff < STEP_W'(CROSS_STEPS)))
      else $error("cross product step out of range");
`endif

endmodule

@@ hdl/vertex_normal_averager.sv @@
// ----------------------------------------------------------------------------
// Vertex normal averager
// Builds smooth vertex normals: stores vertex positions, accumulates unit
// face normals of triangles into per-vertex accumulators and returns the
// normalized accumulated normal of a vertex.
//
//   Channel  Ports                     Direction  Beat
//   req      req_valid / req_ready     in         one operation
//   rsp      rsp_valid / rsp_ready     out        one result per operation
//   csr      csr_we / csr_wdata        in         vertex_count write
//
// A read and an add triangle run the 32-step square root and the 15-step
// dividers, and a triangle may add steps of range reduction; a load does
// neither. Clear writes one accumulator entry a cycle through the single
// write port. After reset the same sweep clears the accumulators before
// the first beat is accepted. A finished result waits in the output
// register while the next beat is accepted; a stalled result holds only
// the final step.
// ----------------------------------------------------------------------------
module vertex_normal_averager import vna_pkg::*; #(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CNT_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic [IDX_W-1:0]         req_index_a,
   input  logic [IDX_W-1:0]         req_index_b,
   input  logic [IDX_W-1:0]         req_index_c,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [NORM_W-1:0] rsp_norm_x,
   output logic signed [NORM_W-1:0] rsp_norm_y,
   output logic signed [NORM_W-1:0] rsp_norm_z,
   output logic [1:0]               rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   vna_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_opcode  (req_opcode),
      .req_index_a (req_index_a),
      .req_index_b (req_index_b),
      .req_index_c (req_index_c),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_norm_x  (rsp_norm_x),
      .rsp_norm_y  (rsp_norm_y),
      .rsp_norm_z  (rsp_norm_z),
      .rsp_status  (rsp_status)
   );

endmodule
